FILE: rtl/dq_pkg.sv
package dq_pkg;

  localparam int unsigned DepthDefault     = 16;
  localparam int unsigned DataWidthDefault = 32;

  localparam int unsigned ValueWidth = 32;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT   = 2'd0,
    MODE_POP_FRONT    = 2'd1,
    MODE_SHIFT_BACK   = 2'd2,
    MODE_UNSHIFT_BACK = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    mode_e                 mode;
    logic [ValueWidth-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic [ValueWidth-1:0] value_out;
    status_e               status;
    logic                  now_empty;
  } rsp_t;

endpackage

FILE: rtl/double_ended_queue.sv
// Latency: the result of an item is strobed on done_o in the cycle after start_i is taken.
// Throughput: one item per cycle; every item not refused touches the ring store exactly
// once, at the edge that accepts it, and removed words come from the store's registered read
// port. busy_o stays low, and the receiver cannot stall, so results never back up.
// Reset clears the front and back indices and the occupancy count; the ring store itself
// is not cleared, since only slots that hold queued words are ever read.
module double_ended_queue #(
  parameter int unsigned DEPTH      = dq_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = dq_pkg::DataWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  dq_pkg::req_t req_i,
  output logic        done_o,
  output dq_pkg::rsp_t rsp_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [IdxW-1:0] front_q, front_d;
  logic [IdxW-1:0] back_q, back_d;
  logic [CntW-1:0] count_q, count_d;

  logic done_q;
  logic is_read_q;
  dq_pkg::status_e status_q, status_d;
  logic now_empty_q;
  logic [DATA_WIDTH-1:0] rd_data_q;

  logic accept;
  logic is_full, is_empty;
  logic wr_en, rd_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  logic [IdxW-1:0] front_inc, front_dec, back_inc, back_dec;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign is_full  = (count_q == CntFull);
  assign is_empty = (count_q == '0);

  assign front_inc = (front_q == IdxLast) ? '0 : front_q + IdxW'(1);
  assign front_dec = (front_q == '0) ? IdxLast : front_q - IdxW'(1);
  assign back_inc  = (back_q == IdxLast) ? '0 : back_q + IdxW'(1);
  assign back_dec  = (back_q == '0) ? IdxLast : back_q - IdxW'(1);

  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    count_d  = count_q;
    status_d = dq_pkg::STATUS_DONE;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = back_q;
    rd_addr  = front_q;
    if (accept) begin
      case (req_i.mode)
        dq_pkg::MODE_PUSH_FRONT: begin
          if (is_full) begin
            status_d = dq_pkg::STATUS_FULL;
          end else begin
            front_d = front_dec;
            wr_en   = 1'b1;
            wr_addr = front_dec;
            count_d = count_q + CntW'(1);
          end
        end
        dq_pkg::MODE_UNSHIFT_BACK: begin
          if (is_full) begin
            status_d = dq_pkg::STATUS_FULL;
          end else begin
            back_d  = back_inc;
            wr_en   = 1'b1;
            wr_addr = back_q;
            count_d = count_q + CntW'(1);
          end
        end
        dq_pkg::MODE_POP_FRONT: begin
          if (is_empty) begin
            status_d = dq_pkg::STATUS_EMPTY;
          end else begin
            front_d = front_inc;
            rd_en   = 1'b1;
            rd_addr = front_q;
            count_d = count_q - CntW'(1);
          end
        end
        dq_pkg::MODE_SHIFT_BACK: begin
          if (is_empty) begin
            status_d = dq_pkg::STATUS_EMPTY;
          end else begin
            back_d  = back_dec;
            rd_en   = 1'b1;
            rd_addr = back_dec;
            count_d = count_q - CntW'(1);
          end
        end
        default: begin
          status_d = dq_pkg::STATUS_DONE;
        end
      endcase
    end
  end

  // Ring store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= DATA_WIDTH'(req_i.value_in);
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      back_q      <= '0;
      count_q     <= '0;
      done_q      <= 1'b0;
      is_read_q   <= 1'b0;
      status_q    <= dq_pkg::STATUS_DONE;
      now_empty_q <= 1'b1;
    end else begin
      front_q     <= front_d;
      back_q      <= back_d;
      count_q     <= count_d;
      done_q      <= accept;
      is_read_q   <= rd_en;
      status_q    <= status_d;
      now_empty_q <= (count_d == '0);
    end
  end

  assign done_o          = done_q;
  assign rsp_o.value_out = is_read_q ? dq_pkg::ValueWidth'(rd_data_q) : '0;
  assign rsp_o.status    = status_q;
  assign rsp_o.now_empty = now_empty_q;

endmodule

FILE: rtl/dq_checker.sv
module dq_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         start_i,
  input logic         busy_o,
  input dq_pkg::req_t req_i,
  input logic         done_o,
  input dq_pkg::rsp_t rsp_o
);

  // Every accepted item gets its result in the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted item produced no result");

  // No result appears without an item accepted the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result without an accepted item");

  // A removal from an empty queue returns zero and leaves the queue empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == dq_pkg::STATUS_EMPTY) |->
      (rsp_o.value_out == '0 && rsp_o.now_empty))
    else $error("empty removal returned data or a non-empty queue");

  // A refused addition leaves a full queue, which is never empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == dq_pkg::STATUS_FULL) |->
      (rsp_o.value_out == '0 && !rsp_o.now_empty))
    else $error("refused addition with data or an empty queue");

  // Additions never return a word, never leave the queue empty and never report an empty status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (req_i.mode == dq_pkg::MODE_PUSH_FRONT ||
                            req_i.mode == dq_pkg::MODE_UNSHIFT_BACK)) |=>
      (rsp_o.value_out == '0 && !rsp_o.now_empty &&
       rsp_o.status != dq_pkg::STATUS_EMPTY))
    else $error("addition result malformed");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);
